// ===== design/srr_pkg.sv =====
// Package for the selective repeat receiver: sizes, field structs,
// result codes and controller states. No dependencies.
`default_nettype none

package srr_pkg;

  localparam int WINDOW       = 8;
  localparam int SEQ_BITS     = 8;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic       KIND_ACK     = 1'b0;
  localparam logic       KIND_DELIVER = 1'b1;

  localparam logic [1:0] CLS_NEW      = 2'd0;
  localparam logic [1:0] CLS_DUP      = 2'd1;
  localparam logic [1:0] CLS_OLD      = 2'd2;
  localparam logic [1:0] CLS_BEYOND   = 2'd3;

  typedef struct packed {
    logic [7:0]  seq_number;
    logic        checksum_ok;
    logic [63:0] payload_word;
  } pkt_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  ack_number;
    logic [1:0]  ack_class;
    logic [63:0] delivered_payload;
    logic        last_result;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_RD,
    S_DLV
  } state_t;

endpackage

`default_nettype wire

// ===== design/selective_repeat_receiver.sv =====
// Selective repeat receiver top level: classification, slot flags,
// payload slot memory and in-order delivery. Depends on srr_pkg.
//
//   channel | direction | handshake            | payload
//   pkt     | in        | pkt_valid, pkt_stall | srr_pkg::pkt_t
//   res     | out       | res_valid, res_stall | srr_pkg::res_t
//
// A packet is taken in S_IDLE and acknowledged from S_ACK once the result
// register is free; each in-order delivery then passes through S_RD for the
// slot memory read and S_DLV to load the result register.
// A corrupt packet is dropped in its accept cycle.
// Reset clears the base, the slot flags and the controller at once.
// A stalled result holds the controller; no packet is taken until the
// last result of the previous one is loaded.
`default_nettype none

module selective_repeat_receiver (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pkt_valid,
  output logic                pkt_stall,
  input  wire srr_pkg::pkt_t  pkt,
  output logic                res_valid,
  input  wire logic           res_stall,
  output srr_pkg::res_t       res
);
  import srr_pkg::*;

  state_t                  state, state_next;
  logic [SEQ_BITS-1:0]     base;
  logic [WINDOW-1:0]       rcvd;
  logic [SEQ_BITS-1:0]     cur_seq;
  logic [PAYLOAD_BITS-1:0] cur_pay;
  logic [PAYLOAD_BITS-1:0] mem [WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_data;

  logic [SEQ_BITS-1:0]     offset;
  logic [SEQ_BITS-1:0]     base_plus;
  logic [SLOT_BITS-1:0]    cur_slot, base_slot, next_slot;
  logic [1:0]              cls;
  logic                    out_free, next_set;
  logic                    take, mem_we, mem_re, res_load, rcvd_set, rcvd_clr, base_inc;
  res_t                    res_next;

  assign offset    = cur_seq - base;
  assign base_plus = base + SEQ_BITS'(1);
  assign cur_slot  = SLOT_BITS'(cur_seq % WINDOW);
  assign base_slot = SLOT_BITS'(base % WINDOW);
  assign next_slot = SLOT_BITS'(base_plus % WINDOW);
  assign out_free  = !res_valid || !res_stall;
  assign next_set  = rcvd[next_slot] && (next_slot != base_slot);

  always_comb begin
    priority if (32'(offset) < WINDOW) begin
      cls = rcvd[cur_slot] ? CLS_DUP : CLS_NEW;
    end else if (offset[SEQ_BITS-1]) begin
      cls = CLS_OLD;
    end else begin
      cls = CLS_BEYOND;
    end
  end

  always_comb begin
    state_next = state;
    pkt_stall  = (state != S_IDLE);
    take       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    res_load   = 1'b0;
    rcvd_set   = 1'b0;
    rcvd_clr   = 1'b0;
    base_inc   = 1'b0;
    res_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (pkt_valid && pkt.checksum_ok) begin
          take       = 1'b1;
          state_next = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_next.result_kind = KIND_ACK;
          res_next.ack_number  = 8'(cur_seq);
          res_next.ack_class   = cls;
          if (cls == CLS_NEW) begin
            mem_we   = 1'b1;
            rcvd_set = 1'b1;
          end
          if (cls == CLS_NEW && cur_seq == base) begin
            res_next.last_result = 1'b0;
            state_next           = S_RD;
          end else begin
            res_next.last_result = 1'b1;
            state_next           = S_IDLE;
          end
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_DLV;
      end
      S_DLV: begin
        if (out_free) begin
          res_load                   = 1'b1;
          res_next.result_kind       = KIND_DELIVER;
          res_next.delivered_payload = 64'(rd_data);
          res_next.last_result       = !next_set;
          rcvd_clr                   = 1'b1;
          base_inc                   = 1'b1;
          state_next                 = next_set ? S_RD : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      rcvd <= '0;
    end else begin
      if (base_inc) begin
        base <= base_plus;
      end
      if (rcvd_set) begin
        rcvd[cur_slot] <= 1'b1;
      end
      if (rcvd_clr) begin
        rcvd[base_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_seq <= SEQ_BITS'(pkt.seq_number);
      cur_pay <= PAYLOAD_BITS'(pkt.payload_word);
    end
  end

  // slot payload memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_slot] <= cur_pay;
    end
    if (mem_re) begin
      rd_data <= mem[base_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_dlv_flagged: assert property (@(posedge clk) disable iff (rst)
    (state == S_DLV) |-> rcvd[base_slot])
    else $error("delivering a slot whose flag is clear");

  a_nonlast_in_drain: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last_result) |-> (state == S_RD || state == S_DLV))
    else $error("non-final result pending outside the delivery run");

  a_base_step: assert property (@(posedge clk) disable iff (rst)
    (base != $past(base)) |-> (base == SEQ_BITS'($past(base) + SEQ_BITS'(1))))
    else $error("window base moved by more than one");
`endif

endmodule

`default_nettype wire
